FILE: sv/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

    localparam int DEPTH  = 64;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        K_PUSH_FRONT = 2'd0,
        K_PUSH_BACK  = 2'd1,
        K_POP_FRONT  = 2'd2,
        K_POP_BACK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [DATA_W-1:0]  value;
    } cmd_word_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  front_value;
        logic signed [DATA_W-1:0]  back_value;
        logic [CNT_W-1:0]          occupancy;
    } res_word_t;

endpackage

FILE: sv/double_ended_queue.sv
// Double-ended queue of signed 32-bit words held in a ring buffer RAM.
// Each command word pushes or pops at either end and yields one result word with the
// status, the front and back values (0 when empty) and the occupancy. Pushes, rejected
// pushes, ignored pops and pops that empty the queue are answered straight from S_IDLE;
// a pop that leaves entries behind goes through S_READ, since the new end value comes
// from the RAM's single registered read port. The front and back values are kept in
// registers, so no other command reads the RAM. One command is in flight at a time; a
// finished result sits in an output register, and the next command is taken as soon as
// that register is free or being emptied in the same cycle.
module double_ended_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  dq_pkg::cmd_word_t cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output dq_pkg::res_word_t res
);

    dq_pkg::state_t              state_reg, state_next;
    logic [dq_pkg::PTR_W-1:0]    front_slot_reg, front_slot_next;
    logic [dq_pkg::PTR_W-1:0]    back_slot_reg, back_slot_next;
    logic [dq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [dq_pkg::DATA_W-1:0]   front_val_reg, front_val_next;
    logic [dq_pkg::DATA_W-1:0]   back_val_reg, back_val_next;
    logic                        pend_front_reg, pend_front_next;
    logic                        res_valid_reg, res_valid_next;
    dq_pkg::res_word_t           res_reg, res_next;

    logic                        accept;
    logic                        is_push;
    logic                        is_front;
    logic                        full;
    logic                        empty;
    logic [dq_pkg::PTR_W-1:0]    front_prev;
    logic [dq_pkg::PTR_W-1:0]    front_succ;
    logic [dq_pkg::PTR_W-1:0]    back_prev;
    logic [dq_pkg::PTR_W-1:0]    back_succ;
    logic [dq_pkg::CNT_W-1:0]    count_inc;
    logic [dq_pkg::CNT_W-1:0]    count_dec;

    logic                        wr_en;
    logic [dq_pkg::PTR_W-1:0]    wr_addr;
    logic                        rd_en;
    logic [dq_pkg::PTR_W-1:0]    rd_addr;
    logic [dq_pkg::DATA_W-1:0]   rd_data;

    dq_ram #(
        .DEPTH (dq_pkg::DEPTH),
        .WIDTH (dq_pkg::DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmd_stall = (state_reg != dq_pkg::S_IDLE) || (res_valid_reg && res_stall);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign is_push  = (cmd.kind == dq_pkg::K_PUSH_FRONT) || (cmd.kind == dq_pkg::K_PUSH_BACK);
    assign is_front = (cmd.kind == dq_pkg::K_PUSH_FRONT) || (cmd.kind == dq_pkg::K_POP_FRONT);
    assign full     = (count_reg == dq_pkg::CNT_W'(dq_pkg::DEPTH));
    assign empty    = (count_reg == '0);

    // ring pointer moves, wrapping at DEPTH
    assign front_prev = (front_slot_reg == '0) ? dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)
                                               : front_slot_reg - 1'b1;
    assign front_succ = (front_slot_reg == dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)) ? '0
                                               : front_slot_reg + 1'b1;
    assign back_prev  = (back_slot_reg == '0) ? dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)
                                              : back_slot_reg - 1'b1;
    assign back_succ  = (back_slot_reg == dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)) ? '0
                                              : back_slot_reg + 1'b1;
    assign count_inc  = count_reg + 1'b1;
    assign count_dec  = count_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dq_pkg::S_IDLE;
            front_slot_reg <= '0;
            back_slot_reg  <= '0;
            count_reg      <= '0;
            pend_front_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_slot_reg <= front_slot_next;
            back_slot_reg  <= back_slot_next;
            count_reg      <= count_next;
            pend_front_reg <= pend_front_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_val_reg <= front_val_next;
        back_val_reg  <= back_val_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        front_slot_next = front_slot_reg;
        back_slot_next  = back_slot_reg;
        count_next      = count_reg;
        front_val_next  = front_val_reg;
        back_val_next   = back_val_reg;
        pend_front_next = pend_front_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = front_slot_reg;
        rd_en           = 1'b0;
        rd_addr         = front_succ;

        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (is_push)
                    begin
                        res_valid_next        = 1'b1;
                        res_next.status       = dq_pkg::ST_DONE;
                        if (full)
                        begin
                            res_next.status      = dq_pkg::ST_FULL;
                            res_next.front_value = front_val_reg;
                            res_next.back_value  = back_val_reg;
                            res_next.occupancy   = count_reg;
                        end
                        else if (empty)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = is_front ? front_slot_reg : back_slot_reg;
                            front_slot_next = wr_addr;
                            back_slot_next  = wr_addr;
                            count_next      = dq_pkg::CNT_W'(1);
                            front_val_next  = cmd.value;
                            back_val_next   = cmd.value;
                            res_next.front_value = cmd.value;
                            res_next.back_value  = cmd.value;
                            res_next.occupancy   = dq_pkg::CNT_W'(1);
                        end
                        else if (is_front)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = front_prev;
                            front_slot_next = front_prev;
                            count_next      = count_inc;
                            front_val_next  = cmd.value;
                            res_next.front_value = cmd.value;
                            res_next.back_value  = back_val_reg;
                            res_next.occupancy   = count_inc;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = back_succ;
                            back_slot_next = back_succ;
                            count_next     = count_inc;
                            back_val_next  = cmd.value;
                            res_next.front_value = front_val_reg;
                            res_next.back_value  = cmd.value;
                            res_next.occupancy   = count_inc;
                        end
                    end
                    else if (empty || count_reg == dq_pkg::CNT_W'(1))
                    begin
                        // ignored pop, or pop that empties: pointers stay put
                        res_valid_next       = 1'b1;
                        res_next.status      = empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_DONE;
                        res_next.front_value = '0;
                        res_next.back_value  = '0;
                        res_next.occupancy   = '0;
                        count_next           = '0;
                    end
                    else
                    begin
                        // fetch the new end value from the RAM
                        count_next      = count_dec;
                        rd_en           = 1'b1;
                        pend_front_next = is_front;
                        state_next      = dq_pkg::S_READ;
                        if (is_front)
                        begin
                            front_slot_next = front_succ;
                            rd_addr         = front_succ;
                        end
                        else
                        begin
                            back_slot_next = back_prev;
                            rd_addr        = back_prev;
                        end
                    end
                end
            end
            dq_pkg::S_READ:
            begin
                // output register was freed when the pop was taken
                res_valid_next       = 1'b1;
                res_next.status      = dq_pkg::ST_DONE;
                res_next.occupancy   = count_reg;
                res_next.front_value = pend_front_reg ? rd_data : front_val_reg;
                res_next.back_value  = pend_front_reg ? back_val_reg : rd_data;
                if (pend_front_reg)
                begin
                    front_val_next = rd_data;
                end
                else
                begin
                    back_val_next = rd_data;
                end
                state_next = dq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/dq_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module dq_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module dq_assertions (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  dq_pkg::cmd_word_t cmd,
    input  logic              res_valid,
    input  logic              res_stall,
    input  dq_pkg::res_word_t res
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.occupancy == '0 |-> res.front_value == '0 && res.back_value == '0)
        else $error("empty queue shows nonzero end values");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == dq_pkg::ST_FULL
            |-> res.occupancy == dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("push rejected while not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == dq_pkg::ST_EMPTY |-> res.occupancy == '0)
        else $error("pop ignored while not empty");

    // a stalled command word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("command word changed while stalled");

endmodule

bind double_ended_queue dq_assertions u_dq_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
